/* sv/block_wall_texel_generator_macros.svh */
// ----------------------------------------------------------------------------
// Block wall texel generator assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BLOCK_WALL_TEXEL_GENERATOR_MACROS_SVH
`define BLOCK_WALL_TEXEL_GENERATOR_MACROS_SVH

// same-cycle implication
`define BWTG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("bwtg assertion failed");

// next-cycle implication
`define BWTG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("bwtg assertion failed");

`endif

/* sv/bwtg_pkg.sv */
// ----------------------------------------------------------------------------
// bwtg_pkg
// Types, constants and arithmetic helpers of the block wall texel generator.
// ----------------------------------------------------------------------------
package bwtg_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int SIZE_W         = 13;
    localparam int COURSE_H_W     = 10;
    localparam int BLOCK_W_W      = 11;
    localparam int MORTAR_W       = 6;

    localparam logic [SIZE_W-1:0] SIZE_MIN   = 13'd8;
    localparam logic [SIZE_W-1:0] SIZE_MAX   = 13'd4096;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd1024;
    localparam logic [MORTAR_W-1:0] MORTAR_MIN = 6'd2;

    localparam logic [31:0] MIX_C1 = 32'h7feb352d;
    localparam logic [31:0] MIX_C2 = 32'h846ca68b;
    localparam logic [31:0] KEY_BX     = 32'd71;
    localparam logic [31:0] KEY_COURSE = 32'd263;
    localparam logic [31:0] KEY_X      = 32'd911;
    localparam logic [31:0] KEY_Y      = 32'd379;

    // 2^16 mod 1000 and 2^16 mod 100
    localparam logic [25:0] FOLD_1000 = 26'd536;
    localparam logic [23:0] FOLD_100  = 24'd36;
    // exact reciprocals: floor(n/1000) for n < 2^26, floor(n/100) for n < 2^23
    localparam logic [26:0] RCP_1000 = 27'd68719477;
    localparam int          SHR_1000 = 36;
    localparam logic [23:0] RCP_100  = 24'd10737419;
    localparam int          SHR_100  = 30;

    localparam int Q_BASE   = 38011;
    localparam int Q_SPREAD = 6554;
    localparam int Q_JOINT  = 34079;
    localparam int Q_GRIT   = 1966;
    localparam int Q_TINT_R = 64225;
    localparam int Q_TINT_G = 64881;
    localparam int Q_TINT_B = 67502;
    localparam int Q_HALF   = 32768;
    localparam int Q_ONE    = 65536;

    typedef struct packed {
        logic [COURSE_H_W-1:0] course_h;
        logic [BLOCK_W_W-1:0]  block_w;
        logic [MORTAR_W-1:0]   mortar;
    } t_geom;

    function automatic t_geom geom_of(input logic [SIZE_W-1:0] n);
        logic [SIZE_W-1:0]   ne;
        logic [MORTAR_W-1:0] m;
        t_geom               g;
        if (n < SIZE_MIN) begin
            ne = SIZE_MIN;
        end else if (n > SIZE_MAX) begin
            ne = SIZE_MAX;
        end else begin
            ne = n;
        end
        m = MORTAR_W'(ne >> 7);
        g.course_h = COURSE_H_W'(ne >> 3);
        g.block_w  = BLOCK_W_W'(ne >> 2);
        g.mortar   = (m < MORTAR_MIN) ? MORTAR_MIN : m;
        return g;
    endfunction

    function automatic logic [31:0] mix_a(input logic [31:0] k);
        logic [31:0] t;
        t = k ^ (k >> 16);
        return t * MIX_C1;
    endfunction

    function automatic logic [31:0] mix_b(input logic [31:0] k);
        logic [31:0] t;
        t = k ^ (k >> 15);
        return t * MIX_C2;
    endfunction

    function automatic logic [31:0] mix_c(input logic [31:0] k);
        return k ^ (k >> 16);
    endfunction

    function automatic logic [15:0] div1000(input logic [25:0] n);
        logic [52:0] p;
        p = 53'(n) * 53'(RCP_1000);
        return 16'(p >> SHR_1000);
    endfunction

    function automatic logic [15:0] div100(input logic [23:0] n);
        logic [47:0] p;
        p = 48'(n) * 48'(RCP_100);
        return 16'(p >> SHR_100);
    endfunction

endpackage

/* sv/bwtg_if.sv */
// ----------------------------------------------------------------------------
// bwtg channel interfaces
// Valid/ready channels for texel coordinates in and color bytes out.
// ----------------------------------------------------------------------------
interface bwtg_coord_if #(
    parameter int COORD_BITS = bwtg_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] col_x;
    logic [COORD_BITS-1:0] row_y;

    modport source (output valid, col_x, row_y, input ready);
    modport sink   (input valid, col_x, row_y, output ready);
endinterface

interface bwtg_color_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface

/* sv/block_wall_texel_generator.sv */
// ----------------------------------------------------------------------------
// block_wall_texel_generator
// Procedural painted block wall: texel coordinate in, RGB bytes out.
// ----------------------------------------------------------------------------
// Accepts one texel per clock while the output is not held and returns one
// color per texel, in order. XS_W is max(COORD_BITS,10)+1; the two long
// divisions by the configured course height and block width retire four
// quotient bits per stage. The whole pipeline stalls together while the
// output is held. texture_size may only be written while no texel is in
// flight; it takes effect on the next accepted texel.
`include "block_wall_texel_generator_macros.svh"

module block_wall_texel_generator #(
    parameter int COORD_BITS = bwtg_pkg::COORD_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bwtg_pkg::SIZE_W-1:0] i_cfg_wdata,
    bwtg_coord_if.sink                  i_coord,
    bwtg_color_if.source                o_color
);

    localparam int CB     = COORD_BITS;
    localparam int XS_W   = ((CB > bwtg_pkg::COURSE_H_W) ? CB : bwtg_pkg::COURSE_H_W) + 1;
    localparam int CH_W   = bwtg_pkg::COURSE_H_W;
    localparam int BW_W   = bwtg_pkg::BLOCK_W_W;
    localparam int D2_SW  = 3 * CB + 1;
    localparam int NTAIL  = 11;

    // tail stage indexes
    localparam int ST_A = 0;
    localparam int ST_J = 9;
    localparam int ST_K = 10;

    bwtg_pkg::t_geom r_geom;

    logic adv;
    logic [NTAIL-1:0] r_vld;

    assign adv           = !r_vld[ST_K] || o_color.ready;
    assign i_coord.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom <= bwtg_pkg::geom_of(bwtg_pkg::SIZE_RESET);
        end else if (i_cfg_we) begin
            r_geom <= bwtg_pkg::geom_of(i_cfg_wdata);
        end
    end

    // course = y / course_h
    logic            d1_vld;
    logic [CB-1:0]   d1_course;
    logic [CH_W-1:0] d1_yrem;
    logic [2*CB-1:0] d1_side;

    bwtg_div #(
        .NUM_W  (CB),
        .DEN_W  (CH_W),
        .SIDE_W (2 * CB),
        .STEPS  (4)
    ) u_div_course (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (i_coord.valid),
        .i_num   (i_coord.row_y),
        .i_den   (r_geom.course_h),
        .i_side  ({i_coord.col_x, i_coord.row_y}),
        .o_vld   (d1_vld),
        .o_quo   (d1_course),
        .o_rem   (d1_yrem),
        .o_side  (d1_side)
    );

    // running bond offset; half a block equals one course height
    logic            r_x_vld;
    logic [CB-1:0]   r_x_course;
    logic [XS_W-1:0] r_x_xs;
    logic            r_x_yj;
    logic [CB-1:0]   r_x_x;
    logic [CB-1:0]   r_x_y;
    logic [XS_W-1:0] n_x_xs;

    always_comb begin
        n_x_xs = XS_W'(d1_side[2*CB-1:CB]);
        if (d1_course[0]) begin
            n_x_xs = n_x_xs + XS_W'(r_geom.course_h);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_vld <= 1'b0;
        end else if (adv) begin
            r_x_vld <= d1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x_course <= d1_course;
            r_x_xs     <= n_x_xs;
            r_x_yj     <= d1_yrem < CH_W'(r_geom.mortar);
            r_x_x      <= d1_side[2*CB-1:CB];
            r_x_y      <= d1_side[CB-1:0];
        end
    end

    // bx = xs / block_w
    logic             d2_vld;
    logic [XS_W-1:0]  d2_bx;
    logic [BW_W-1:0]  d2_xrem;
    logic [D2_SW-1:0] d2_side;
    logic [CB-1:0]    d2_course;
    logic             d2_yj;
    logic [CB-1:0]    d2_x;
    logic [CB-1:0]    d2_y;

    bwtg_div #(
        .NUM_W  (XS_W),
        .DEN_W  (BW_W),
        .SIDE_W (D2_SW),
        .STEPS  (4)
    ) u_div_block (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_vld   (r_x_vld),
        .i_num   (r_x_xs),
        .i_den   (r_geom.block_w),
        .i_side  ({r_x_course, r_x_yj, r_x_x, r_x_y}),
        .o_vld   (d2_vld),
        .o_quo   (d2_bx),
        .o_rem   (d2_xrem),
        .o_side  (d2_side)
    );

    assign {d2_course, d2_yj, d2_x, d2_y} = d2_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NTAIL-2:0], d2_vld};
        end
    end

    // tail payload
    logic [31:0] r_a_k1, r_a_k2, r_b_k1, r_b_k2, r_c_k1, r_c_k2;
    logic        r_a_jt, r_b_jt, r_c_jt, r_d_jt, r_e_jt, r_f_jt, r_g_jt, r_h_jt;
    logic [25:0] r_d_h1f, r_e_h1f;
    logic [23:0] r_d_h2f, r_e_h2f;
    logic [15:0] r_e_q1, r_e_q2;
    logic [9:0]  r_f_h1;
    logic [6:0]  r_f_h2;
    logic [15:0] r_g_f1, r_g_f2;
    logic signed [17:0] r_h_v0, r_i_vj;
    logic signed [11:0] r_h_grit, r_i_grit;
    logic signed [19:0] r_j_cr, r_j_cg, r_j_cb;
    logic [7:0]  r_k_red, r_k_green, r_k_blue;

    logic [31:0] n_d_k1, n_d_k2;
    logic signed [16:0] n_h_t1, n_h_t2;
    logic signed [31:0] n_h_p1, n_h_p2, n_i_pj;
    logic signed [17:0] n_j_v;
    logic signed [35:0] n_j_pr, n_j_pg, n_j_pb;

    function automatic logic [7:0] to_byte(input logic signed [19:0] c);
        logic [16:0] cl;
        logic [24:0] p;
        if (c < 20'sd0) begin
            cl = 17'd0;
        end else if (c > 20'(bwtg_pkg::Q_ONE)) begin
            cl = 17'(bwtg_pkg::Q_ONE);
        end else begin
            cl = 17'(c);
        end
        p = 25'(cl) * 25'd255;
        return 8'(p >> 16);
    endfunction

    always_comb begin
        n_d_k1 = bwtg_pkg::mix_c(r_c_k1);
        n_d_k2 = bwtg_pkg::mix_c(r_c_k2);
        n_h_t1 = $signed({1'b0, r_g_f1}) - 17'(bwtg_pkg::Q_HALF);
        n_h_t2 = $signed({1'b0, r_g_f2}) - 17'(bwtg_pkg::Q_HALF);
        n_h_p1 = 32'(n_h_t1) * 32'(bwtg_pkg::Q_SPREAD);
        n_h_p2 = 32'(n_h_t2) * 32'(bwtg_pkg::Q_GRIT);
        n_i_pj = 32'(r_h_v0) * 32'(bwtg_pkg::Q_JOINT);
        n_j_v  = r_i_vj + 18'(r_i_grit);
        n_j_pr = 36'(n_j_v) * 36'(bwtg_pkg::Q_TINT_R);
        n_j_pg = 36'(n_j_v) * 36'(bwtg_pkg::Q_TINT_G);
        n_j_pb = 36'(n_j_v) * 36'(bwtg_pkg::Q_TINT_B);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            // A: hash keys and joint flag
            r_a_k1 <= 32'(d2_bx) * bwtg_pkg::KEY_BX + 32'(d2_course) * bwtg_pkg::KEY_COURSE;
            r_a_k2 <= 32'(d2_x) * bwtg_pkg::KEY_X + 32'(d2_y) * bwtg_pkg::KEY_Y;
            r_a_jt <= d2_yj || (d2_xrem < BW_W'(r_geom.mortar));
            // B, C: hash multiplies
            r_b_k1 <= bwtg_pkg::mix_a(r_a_k1);
            r_b_k2 <= bwtg_pkg::mix_a(r_a_k2);
            r_b_jt <= r_a_jt;
            r_c_k1 <= bwtg_pkg::mix_b(r_b_k1);
            r_c_k2 <= bwtg_pkg::mix_b(r_b_k2);
            r_c_jt <= r_b_jt;
            // D: final xor-shift, then fold the high half by 2^16 mod m
            r_d_h1f <= 26'(n_d_k1[31:16]) * bwtg_pkg::FOLD_1000 + 26'(n_d_k1[15:0]);
            r_d_h2f <= 24'(n_d_k2[31:16]) * bwtg_pkg::FOLD_100 + 24'(n_d_k2[15:0]);
            r_d_jt  <= r_c_jt;
            // E: quotients by reciprocal
            r_e_q1  <= bwtg_pkg::div1000(r_d_h1f);
            r_e_q2  <= bwtg_pkg::div100(r_d_h2f);
            r_e_h1f <= r_d_h1f;
            r_e_h2f <= r_d_h2f;
            r_e_jt  <= r_d_jt;
            // F: remainders
            r_f_h1 <= 10'(r_e_h1f - 26'(r_e_q1) * 26'd1000);
            r_f_h2 <= 7'(r_e_h2f - 24'(r_e_q2) * 24'd100);
            r_f_jt <= r_e_jt;
            // G: scale to Q16
            r_g_f1 <= bwtg_pkg::div1000({r_f_h1, 16'd0});
            r_g_f2 <= bwtg_pkg::div100(24'({r_f_h2, 16'd0}));
            r_g_jt <= r_f_jt;
            // H: block tone and speckle
            r_h_v0   <= 18'(bwtg_pkg::Q_BASE) + 18'(n_h_p1 >>> 16);
            r_h_grit <= 12'(n_h_p2 >>> 16);
            r_h_jt   <= r_g_jt;
            // I: joint darkening
            r_i_vj   <= r_h_jt ? 18'(n_i_pj >>> 16) : r_h_v0;
            r_i_grit <= r_h_grit;
            // J: tint
            r_j_cr <= 20'(n_j_pr >>> 16);
            r_j_cg <= 20'(n_j_pg >>> 16);
            r_j_cb <= 20'(n_j_pb >>> 16);
            // K: clamp and byte
            r_k_red   <= to_byte(r_j_cr);
            r_k_green <= to_byte(r_j_cg);
            r_k_blue  <= to_byte(r_j_cb);
        end
    end

    assign o_color.valid = r_vld[ST_K];
    assign o_color.red   = r_k_red;
    assign o_color.green = r_k_green;
    assign o_color.blue  = r_k_blue;

    `BWTG_ASSERT_IMPL(a_stall_blocks_input, o_color.valid && !o_color.ready, !i_coord.ready)
    `BWTG_ASSERT_NEXT(a_tail_reaches_output, r_vld[ST_J] && adv, o_color.valid)
    `BWTG_ASSERT_IMPL(a_geom_half_block, 1'b1, (r_geom.block_w >> 1) == BW_W'(r_geom.course_h))
    `BWTG_ASSERT_IMPL(a_geom_mortar_min, 1'b1, r_geom.mortar >= bwtg_pkg::MORTAR_MIN)
    `BWTG_ASSERT_IMPL(a_tint_order, o_color.valid && r_vld[ST_A] == r_vld[ST_A],
                      o_color.blue >= o_color.red && o_color.green >= o_color.red)

endmodule

/* sv/bwtg_div.sv */
// ----------------------------------------------------------------------------
// bwtg_div
// Pipelined restoring divider, STEPS quotient bits per stage, with a sidecar.
// ----------------------------------------------------------------------------
module bwtg_div #(
    parameter int NUM_W  = 12,
    parameter int DEN_W  = 10,
    parameter int SIDE_W = 1,
    parameter int STEPS  = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_vld,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_vld,
    output logic [NUM_W-1:0]  o_quo,
    output logic [DEN_W-1:0]  o_rem,
    output logic [SIDE_W-1:0] o_side
);

    localparam int NSTG  = (NUM_W + STEPS - 1) / STEPS;
    localparam int PAD_W = NSTG * STEPS;
    localparam int WK_W  = DEN_W + PAD_W;

    // work word: remainder above, dividend bits shifting out / quotient in below
    logic [WK_W-1:0]   r_work [NSTG];
    logic [WK_W-1:0]   n_work [NSTG];
    logic [SIDE_W-1:0] r_side [NSTG];
    logic [SIDE_W-1:0] n_side [NSTG];
    logic [NSTG-1:0]   r_vld;

    always_comb begin
        logic [WK_W-1:0]  src;
        logic [DEN_W-1:0] rem;
        logic [PAD_W-1:0] num;
        logic [DEN_W:0]   trial;
        for (int s = 0; s < NSTG; s++) begin
            if (s == 0) begin
                src       = WK_W'(i_num);
                n_side[s] = i_side;
            end else begin
                src       = r_work[s-1];
                n_side[s] = r_side[s-1];
            end
            rem = src[WK_W-1:PAD_W];
            num = src[PAD_W-1:0];
            for (int k = 0; k < STEPS; k++) begin
                trial = {rem, num[PAD_W-1]};
                if (trial >= {1'b0, i_den}) begin
                    trial = trial - {1'b0, i_den};
                    num   = {num[PAD_W-2:0], 1'b1};
                end else begin
                    num   = {num[PAD_W-2:0], 1'b0};
                end
                rem = trial[DEN_W-1:0];
            end
            n_work[s] = {rem, num};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= NSTG'({r_vld, i_vld});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NSTG; s++) begin
                r_work[s] <= n_work[s];
                r_side[s] <= n_side[s];
            end
        end
    end

    assign o_vld  = r_vld[NSTG-1];
    assign o_quo  = r_work[NSTG-1][NUM_W-1:0];
    assign o_rem  = r_work[NSTG-1][WK_W-1:PAD_W];
    assign o_side = r_side[NSTG-1];

endmodule
